### hw/rtl/pdsc_pkg.sv
`default_nettype none
package pdsc_pkg;

  // widest accumulated sum: sixteen full-scale samples
  localparam int SUM_MAX_W = 20;
  localparam int QDEPTH    = 2;
  localparam int DIV_STEPS = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PU     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_VOTES  = 3'd7;

  localparam logic [16:0] Q15_ONE = 17'd32768;

  typedef struct packed {
    logic [15:0] high_count;
    logic [15:0] period_count;
    logic        dir_pin;
    logic        pwm_pin_level;
    logic        dir_check_enable;
  } pdsc_in_t;

  typedef struct packed {
    logic signed [15:0] target_speed;
    logic signed [15:0] target_speed_pu;
    logic               backward;
  } pdsc_out_t;

  typedef struct packed {
    logic [15:0] min_duty_q15;
    logic [15:0] max_duty_q15;
    logic [15:0] gain_factor;
    logic [14:0] min_speed;
    logic [14:0] max_speed;
    logic [14:0] full_scale_speed;
    logic [14:0] max_speed_pu;
    logic [7:0]  direction_votes;
  } pdsc_cfg_t;

  // one averaging request handed from front to back
  typedef struct packed {
    logic [SUM_MAX_W-1:0] high_sum;
    logic [SUM_MAX_W-1:0] period_sum;
    logic                 pin_level;
    logic                 polarity;
  } pdsc_job_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } pdsc_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } pdsc_div_rsp_t;

endpackage
`default_nettype wire

### hw/rtl/pdsc_div.sv
`default_nettype none
module pdsc_div
  import pdsc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pdsc_div_req_t req,
  output pdsc_div_rsp_t      rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [16:0] rem_shift;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dvs_nxt   = dvs_r;
    rem_shift = {rem_r[15:0], quo_r[31]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // restoring step: one quotient bit per cycle
      if (rem_shift >= {1'b0, dvs_r}) begin
        rem_nxt = rem_shift - {1'b0, dvs_r};
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = rem_shift;
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

### hw/rtl/pdsc_queue.sv
`default_nettype none
module pdsc_queue
  import pdsc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire pdsc_job_t push_data,
  output logic           full,
  input  wire logic      pop,
  output pdsc_job_t      pop_data,
  output logic           empty
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  pdsc_job_t        slot_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pdsc_front.sv
`default_nettype none
module pdsc_front
  import pdsc_pkg::*;
#(
  parameter int AVG_SAMPLES = 8,
  parameter int DIR_WINDOW  = 10
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_push,
  input  wire pdsc_in_t  in_data,
  output logic           in_full,
  input  wire logic [7:0] direction_votes,
  output logic           q_push,
  output pdsc_job_t      q_data,
  input  wire logic      q_full
);

  localparam int CNT_W = $clog2(AVG_SAMPLES + 1);
  localparam int SUM_W = 16 + $clog2(AVG_SAMPLES);
  localparam int WIN_W = $clog2(DIR_WINDOW + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] hsum_r, hsum_nxt;
  logic [SUM_W-1:0] psum_r, psum_nxt;
  logic [WIN_W-1:0] win_r, win_nxt;
  logic [WIN_W-1:0] fvote_r, fvote_nxt;
  logic [WIN_W-1:0] bvote_r, bvote_nxt;
  logic             pol_r, pol_nxt;
  logic             acc;
  logic             avg_due;

  assign avg_due = (cnt_r == CNT_W'(AVG_SAMPLES));
  // only the averaging item needs room in the queue
  assign in_full = q_full && avg_due;
  assign acc     = in_push && !in_full;

  always_comb begin
    win_nxt   = win_r;
    fvote_nxt = fvote_r;
    bvote_nxt = bvote_r;
    pol_nxt   = pol_r;
    if (acc && in_data.dir_check_enable) begin
      if (win_r < WIN_W'(DIR_WINDOW)) begin
        win_nxt = win_r + WIN_W'(1);
        if (in_data.dir_pin) begin
          bvote_nxt = bvote_r + WIN_W'(1);
        end else begin
          fvote_nxt = fvote_r + WIN_W'(1);
        end
      end else begin
        // decide, drop this pin sample, restart the window
        if (9'(fvote_r) >= {1'b0, direction_votes}) begin
          pol_nxt = 1'b0;
        end else if (9'(bvote_r) >= {1'b0, direction_votes}) begin
          pol_nxt = 1'b1;
        end
        win_nxt   = '0;
        fvote_nxt = '0;
        bvote_nxt = '0;
      end
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    hsum_nxt = hsum_r;
    psum_nxt = psum_r;
    q_push   = 1'b0;
    if (acc) begin
      if (!avg_due) begin
        cnt_nxt  = cnt_r + CNT_W'(1);
        hsum_nxt = hsum_r + SUM_W'(in_data.high_count);
        psum_nxt = psum_r + SUM_W'(in_data.period_count);
      end else begin
        cnt_nxt  = '0;
        hsum_nxt = '0;
        psum_nxt = '0;
        q_push   = 1'b1;
      end
    end
  end

  assign q_data.high_sum   = SUM_MAX_W'(hsum_r);
  assign q_data.period_sum = SUM_MAX_W'(psum_r);
  assign q_data.pin_level  = in_data.pwm_pin_level;
  assign q_data.polarity   = pol_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      hsum_r  <= '0;
      psum_r  <= '0;
      win_r   <= '0;
      fvote_r <= '0;
      bvote_r <= '0;
      pol_r   <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      hsum_r  <= hsum_nxt;
      psum_r  <= psum_nxt;
      win_r   <= win_nxt;
      fvote_r <= fvote_nxt;
      bvote_r <= bvote_nxt;
      pol_r   <= pol_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pdsc_back.sv
`default_nettype none
module pdsc_back
  import pdsc_pkg::*;
#(
  parameter int AVG_SAMPLES = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pdsc_cfg_t     cfg,
  input  wire logic          q_empty,
  input  wire pdsc_job_t     q_data,
  output logic               q_pop,
  output pdsc_div_req_t      div_req,
  input  wire pdsc_div_rsp_t div_rsp,
  output logic               out_empty,
  input  wire logic          out_pop,
  output pdsc_out_t          out_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HAVG = 3'd1;
  localparam logic [2:0] ST_PAVG = 3'd2;
  localparam logic [2:0] ST_DUTY = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_LIN  = 3'd5;
  localparam logic [2:0] ST_PU   = 3'd6;

  // exact reciprocal of the sample count for any sum below 2**SUM_MAX_W
  localparam int AVG_SH = SUM_MAX_W + $clog2(AVG_SAMPLES);
  localparam int RCP_W  = SUM_MAX_W + 2;
  localparam int PRD_W  = SUM_MAX_W + RCP_W;
  localparam logic [RCP_W-1:0] AVG_RCP =
    RCP_W'(((64'd1 << AVG_SH) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));

  logic [2:0]  state_r, state_nxt;
  pdsc_job_t   job_r, job_nxt;
  logic [15:0] havg_r, havg_nxt;
  logic [15:0] pavg_r, pavg_nxt;
  logic [16:0] comp_r, comp_nxt;
  logic [32:0] prod_r, prod_nxt;
  logic [14:0] mag_r, mag_nxt;
  logic        oval_r, oval_nxt;
  pdsc_out_t   odat_r, odat_nxt;

  logic [PRD_W-1:0] hprod, pprod;
  logic [16:0] min_ext, max_ext, diff;
  logic [22:0] lin;
  logic [14:0] pumag;
  logic [14:0] fs;
  logic        neg;

  assign hprod   = PRD_W'(job_r.high_sum) * PRD_W'(AVG_RCP);
  assign pprod   = PRD_W'(job_r.period_sum) * PRD_W'(AVG_RCP);
  assign min_ext = {1'b0, cfg.min_duty_q15};
  assign max_ext = {1'b0, cfg.max_duty_q15};
  assign diff    = comp_r - min_ext;
  assign fs      = (cfg.full_scale_speed == '0) ? 15'd1 : cfg.full_scale_speed;
  assign lin     = 23'(prod_r[32:15]) * 23'd10 + 23'(cfg.min_speed);
  assign pumag   = (div_rsp.quotient > 32'(cfg.max_speed_pu)) ? cfg.max_speed_pu
                                                             : div_rsp.quotient[14:0];
  assign neg     = job_r.polarity && (mag_r != '0);

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    havg_nxt  = havg_r;
    pavg_nxt  = pavg_r;
    comp_nxt  = comp_r;
    prod_nxt  = prod_r;
    mag_nxt   = mag_r;
    oval_nxt  = oval_r;
    odat_nxt  = odat_r;
    q_pop     = 1'b0;
    div_req   = '0;
    if (out_pop && oval_r) begin
      oval_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (!q_empty && !oval_r) begin
          q_pop     = 1'b1;
          job_nxt   = q_data;
          state_nxt = ST_HAVG;
        end
      end
      ST_HAVG: begin
        havg_nxt  = hprod[AVG_SH +: 16];
        pavg_nxt  = pprod[AVG_SH +: 16];
        state_nxt = ST_PAVG;
      end
      ST_PAVG: begin
        if (pavg_r == '0) begin
          // no period seen: pin level picks stop or full speed
          oval_nxt = 1'b1;
          odat_nxt.backward = job_r.polarity;
          if (job_r.pin_level) begin
            odat_nxt.target_speed    = '0;
            odat_nxt.target_speed_pu = '0;
          end else begin
            odat_nxt.target_speed    = {1'b0, cfg.max_speed};
            odat_nxt.target_speed_pu = {1'b0, cfg.max_speed_pu};
          end
          state_nxt = ST_IDLE;
        end else if (havg_r >= pavg_r) begin
          comp_nxt  = '0;
          state_nxt = ST_MUL;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {1'b0, havg_r, 15'd0};
          div_req.divisor  = pavg_r;
          state_nxt        = ST_DUTY;
        end
      end
      ST_DUTY: begin
        if (div_rsp.done) begin
          comp_nxt  = Q15_ONE - {1'b0, div_rsp.quotient[15:0]};
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = 33'(cfg.gain_factor) * 33'(diff);
        state_nxt = ST_LIN;
      end
      ST_LIN: begin
        if (comp_r < min_ext) begin
          mag_nxt = '0;
        end else if (comp_r > max_ext) begin
          mag_nxt = cfg.max_speed;
        end else if (lin > 23'd32767) begin
          mag_nxt = 15'h7fff;
        end else begin
          mag_nxt = lin[14:0];
        end
        div_req.start    = 1'b1;
        div_req.dividend = {2'b00, mag_nxt, 15'd0};
        div_req.divisor  = {1'b0, fs};
        state_nxt        = ST_PU;
      end
      ST_PU: begin
        if (div_rsp.done) begin
          oval_nxt          = 1'b1;
          odat_nxt.backward = job_r.polarity;
          odat_nxt.target_speed    = neg ? (16'd0 - {1'b0, mag_r}) : {1'b0, mag_r};
          odat_nxt.target_speed_pu = neg ? (16'd0 - {1'b0, pumag}) : {1'b0, pumag};
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
    job_r  <= job_nxt;
    havg_r <= havg_nxt;
    pavg_r <= pavg_nxt;
    comp_r <= comp_nxt;
    prod_r <= prod_nxt;
    mag_r  <= mag_nxt;
    odat_r <= odat_nxt;
  end

  assign out_empty = !oval_r;
  assign out_data  = odat_r;

endmodule
`default_nettype wire

### hw/rtl/pwm_duty_speed_command.sv
// Each result takes two passes of the 32-step divider, one pass when high time is not
//   below period and none for a zero period.
// Throughput: one request per cycle into the front while in_full is low; one result per
//   AVG_SAMPLES+1 requests; the back end works one job at a time behind a two-entry queue.
// Reset (synchronous, rst_n low): counts, sums and votes clear, direction forward,
//   registers return to their defaults, queue and result slot empty.
`default_nettype none
module pwm_duty_speed_command
  import pdsc_pkg::*;
#(
  parameter int AVG_SAMPLES = 8,
  parameter int DIR_WINDOW  = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  input  wire pdsc_in_t             in_data,
  output logic                      in_full,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output pdsc_out_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  pdsc_cfg_t     cfg_r, cfg_nxt;
  logic          q_push, q_full, q_pop, q_empty;
  pdsc_job_t     q_wdata, q_rdata;
  pdsc_div_req_t div_req;
  pdsc_div_rsp_t div_rsp;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_DUTY:   cfg_nxt.min_duty_q15     = cfg_data;
        CFG_MAX_DUTY:   cfg_nxt.max_duty_q15     = cfg_data;
        CFG_GAIN:       cfg_nxt.gain_factor      = cfg_data;
        CFG_MIN_SPEED:  cfg_nxt.min_speed        = cfg_data[14:0];
        CFG_MAX_SPEED:  cfg_nxt.max_speed        = cfg_data[14:0];
        CFG_FULL_SCALE: cfg_nxt.full_scale_speed = cfg_data[14:0];
        CFG_MAX_PU:     cfg_nxt.max_speed_pu     = cfg_data[14:0];
        CFG_DIR_VOTES:  cfg_nxt.direction_votes  = cfg_data[7:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_duty_q15     <= 16'd4915;
      cfg_r.max_duty_q15     <= 16'd21299;
      cfg_r.gain_factor      <= 16'd220;
      cfg_r.min_speed        <= 15'd0;
      cfg_r.max_speed        <= 15'd0;
      cfg_r.full_scale_speed <= 15'd1;
      cfg_r.max_speed_pu     <= 15'd32767;
      cfg_r.direction_votes  <= 8'd7;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pdsc_front #(
    .AVG_SAMPLES (AVG_SAMPLES),
    .DIR_WINDOW  (DIR_WINDOW)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_data         (in_data),
    .in_full         (in_full),
    .direction_votes (cfg_r.direction_votes),
    .q_push          (q_push),
    .q_data          (q_wdata),
    .q_full          (q_full)
  );

  pdsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  pdsc_back #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  pdsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule
`default_nettype wire

### hw/rtl/pdsc_port_chk.sv
`default_nettype none
module pdsc_port_chk
  import pdsc_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_push,
  input wire pdsc_in_t             in_data,
  input wire logic                 in_full,
  input wire logic                 out_empty,
  input wire logic                 out_pop,
  input wire pdsc_out_t            out_data,
  input wire logic                 cfg_we,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [15:0]          cfg_data
);

  // reset leaves both sides empty
  a_reset_out_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending right after reset");

  a_reset_in_open: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full right after reset");

  // a result waiting to be taken holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("pending result changed before pop");

  // the next result needs a new back-end job, never the next cycle
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop) |=> out_empty)
    else $error("result right after pop");

  // a negative speed only comes with a backward direction
  a_sign_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.target_speed[15]) |-> out_data.backward)
    else $error("negative speed with forward direction");

endmodule

bind pwm_duty_speed_command pdsc_port_chk u_port_chk (.*);
`default_nettype wire

### test/pwm_speed_checker.sv
`timescale 1ns / 1ps
module pwm_speed_checker
  import pdsc_pkg::*;
#(
  parameter int AVG_SAMPLES = 8,
  parameter int DIR_WINDOW  = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_full,
  input  pdsc_in_t             in_data,
  input  logic                 out_empty,
  input  logic                 out_pop,
  input  pdsc_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   mismatch_count,
  output int                   pending_speeds
);

  pdsc_cfg_t   settings;
  int unsigned sample_count;
  logic [31:0] high_sum;
  logic [31:0] period_sum;
  int unsigned vote_window;
  int unsigned forward_votes;
  int unsigned backward_votes;
  logic        backward_dir;
  pdsc_out_t   expected_speeds[$];
  int          errors = 0;

  function automatic pdsc_out_t predict_speed(input logic [31:0] h_sum, input logic [31:0] p_sum,
                                              input logic pin_high);
    logic [31:0] h_avg;
    logic [31:0] p_avg;
    logic [31:0] duty;
    logic [31:0] comp;
    logic [31:0] mag;
    logic [31:0] pu_mag;
    logic [31:0] fs;
    logic [31:0] signed_speed;
    logic [31:0] signed_pu;
    logic        neg;
    pdsc_out_t   res;
    h_avg = h_sum / AVG_SAMPLES;
    p_avg = p_sum / AVG_SAMPLES;
    res.backward = backward_dir;
    // zero period: pin level picks stopped or full speed, no polarity
    if (p_avg == 0) begin
      res.target_speed    = pin_high ? 16'd0 : {1'b0, settings.max_speed};
      res.target_speed_pu = pin_high ? 16'd0 : {1'b0, settings.max_speed_pu};
      return res;
    end
    if (h_avg >= p_avg) begin
      duty = 32'd32768;
    end else begin
      duty = (32'd32768 * h_avg) / p_avg;
    end
    comp = 32'd32768 - duty;
    if (comp < 32'(settings.min_duty_q15)) begin
      mag = 0;
    end else if (comp > 32'(settings.max_duty_q15)) begin
      mag = 32'(settings.max_speed);
    end else begin
      mag = ((32'(settings.gain_factor) * (comp - 32'(settings.min_duty_q15))) >> 15) * 10
            + 32'(settings.min_speed);
      if (mag > 32767) mag = 32767;
    end
    neg = backward_dir && (mag != 0);
    fs = (settings.full_scale_speed == 0) ? 32'd1 : 32'(settings.full_scale_speed);
    pu_mag = (mag * 32'd32768) / fs;
    if (pu_mag > 32'(settings.max_speed_pu)) pu_mag = 32'(settings.max_speed_pu);
    signed_speed = neg ? (~mag + 1) : mag;
    signed_pu = neg ? (~pu_mag + 1) : pu_mag;
    res.target_speed    = signed_speed[15:0];
    res.target_speed_pu = signed_pu[15:0];
    return res;
  endfunction

  task automatic step_model(input pdsc_in_t req);
    if (req.dir_check_enable) begin
      if (vote_window < DIR_WINDOW) begin
        vote_window++;
        if (req.dir_pin) backward_votes++;
        else forward_votes++;
      end else begin
        // decide, forward first; drop this pin sample
        if (forward_votes >= 32'(settings.direction_votes)) backward_dir = 1'b0;
        else if (backward_votes >= 32'(settings.direction_votes)) backward_dir = 1'b1;
        vote_window = 0;
        forward_votes = 0;
        backward_votes = 0;
      end
    end
    if (sample_count < AVG_SAMPLES) begin
      sample_count++;
      high_sum += 32'(req.high_count);
      period_sum += 32'(req.period_count);
    end else begin
      expected_speeds.push_back(predict_speed(high_sum, period_sum, req.pwm_pin_level));
      sample_count = 0;
      high_sum = 0;
      period_sum = 0;
    end
  endtask

  always @(posedge clk) begin
    pdsc_out_t want;
    if (!rst_n) begin
      settings.min_duty_q15     = 16'd4915;
      settings.max_duty_q15     = 16'd21299;
      settings.gain_factor      = 16'd220;
      settings.min_speed        = 15'd0;
      settings.max_speed        = 15'd0;
      settings.full_scale_speed = 15'd1;
      settings.max_speed_pu     = 15'd32767;
      settings.direction_votes  = 8'd7;
      sample_count   = 0;
      high_sum       = 0;
      period_sum     = 0;
      vote_window    = 0;
      forward_votes  = 0;
      backward_votes = 0;
      backward_dir   = 1'b0;
      expected_speeds.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_speeds.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result speed=%0d pu=%0d backward=%0b", $realtime,
                     out_data.target_speed, out_data.target_speed_pu, out_data.backward);
        end else begin
          want = expected_speeds.pop_front();
          if (out_data.target_speed !== want.target_speed ||
              out_data.target_speed_pu !== want.target_speed_pu ||
              out_data.backward !== want.backward) begin
            errors++;
            if (errors <= 10)
              $display("%0t: expected speed=%0d pu=%0d backward=%0b, got %0d %0d %0b",
                       $realtime, want.target_speed, want.target_speed_pu, want.backward,
                       out_data.target_speed, out_data.target_speed_pu, out_data.backward);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_DUTY:   settings.min_duty_q15     = cfg_data;
          CFG_MAX_DUTY:   settings.max_duty_q15     = cfg_data;
          CFG_GAIN:       settings.gain_factor      = cfg_data;
          CFG_MIN_SPEED:  settings.min_speed        = cfg_data[14:0];
          CFG_MAX_SPEED:  settings.max_speed        = cfg_data[14:0];
          CFG_FULL_SCALE: settings.full_scale_speed = cfg_data[14:0];
          CFG_MAX_PU:     settings.max_speed_pu     = cfg_data[14:0];
          CFG_DIR_VOTES:  settings.direction_votes  = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) step_model(in_data);
    end
    pending_speeds <= expected_speeds.size();
    mismatch_count <= errors;
  end

endmodule

### test/pwm_duty_speed_command_tb.sv
`timescale 1ns / 1ps
module pwm_duty_speed_command_tb;
  import pdsc_pkg::*;

  localparam int AVG_SAMPLES  = 8;
  localparam int DIR_WINDOW   = 10;
  localparam int RANDOM_ITEMS = 1950;
  localparam int SEGMENTS     = 5;
  localparam int SETTLE       = 300;
  localparam int CYCLE_LIMIT  = 400000;

  localparam int SET_TYPICAL = 0;
  localparam int SET_HIGH    = 1;
  localparam int SET_LOW     = 2;
  localparam int SET_RANDOM  = 3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  pdsc_in_t             in_data = '0;
  logic                 in_full;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  pdsc_out_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  int mismatch_count;
  int pending_speeds;
  int tx_idle_pct = 13;
  int rx_idle_pct = 50;
  int cycles = 0;

  pwm_duty_speed_command #(
    .AVG_SAMPLES(AVG_SAMPLES),
    .DIR_WINDOW (DIR_WINDOW)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pwm_speed_checker #(
    .AVG_SAMPLES(AVG_SAMPLES),
    .DIR_WINDOW (DIR_WINDOW)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_data       (in_data),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .pending_speeds(pending_speeds)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_pop <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic pdsc_cfg_t settings_for(input int kind);
    pdsc_cfg_t c;
    case (kind)
      SET_TYPICAL: begin
        c = '{16'd4915, 16'd21299, 16'd220, 15'd300, 15'd3000, 15'd4000, 15'd32767, 8'd7};
      end
      SET_HIGH: begin
        // full scale of zero counts as one
        c = '{16'd0, 16'd32768, 16'd65535, 15'd32767, 15'd32767, 15'd0, 15'd32767, 8'd255};
      end
      SET_LOW: begin
        c = '{16'd32768, 16'd0, 16'd0, 15'd0, 15'd0, 15'd32767, 15'd0, 8'd0};
      end
      default: begin
        c.min_duty_q15 = 16'($urandom_range(0, 16384));
        c.max_duty_q15 = 16'($urandom_range(c.min_duty_q15, 32768));
        if ($urandom_range(0, 7) == 0) begin
          c.min_duty_q15 = 16'($urandom_range(0, 32768));
          c.max_duty_q15 = 16'($urandom_range(0, 32768));
        end
        c.gain_factor      = 16'($urandom_range(0, 65535));
        c.min_speed        = 15'($urandom_range(0, 1) ? $urandom_range(0, 3000)
                                                      : $urandom_range(0, 32767));
        c.max_speed        = 15'($urandom_range(0, 32767));
        c.full_scale_speed = 15'($urandom_range(1, 32767));
        c.max_speed_pu     = 15'($urandom_range(0, 32767));
        c.direction_votes  = 8'(($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 11));
      end
    endcase
    return c;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic write_settings(input pdsc_cfg_t c);
    write_reg(CFG_MIN_DUTY, c.min_duty_q15);
    write_reg(CFG_MAX_DUTY, c.max_duty_q15);
    write_reg(CFG_GAIN, c.gain_factor);
    write_reg(CFG_MIN_SPEED, {1'b0, c.min_speed});
    write_reg(CFG_MAX_SPEED, {1'b0, c.max_speed});
    write_reg(CFG_FULL_SCALE, {1'b0, c.full_scale_speed});
    write_reg(CFG_MAX_PU, {1'b0, c.max_speed_pu});
    write_reg(CFG_DIR_VOTES, {8'd0, c.direction_votes});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_request(input pdsc_in_t req);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic send_set(input logic [15:0] h, input logic [15:0] p, input logic level,
                          input logic pin, input logic en);
    pdsc_in_t req;
    req = '{h, p, pin, level, en};
    for (int i = 0; i <= AVG_SAMPLES; i++) send_request(req);
  endtask

  task automatic send_random_set();
    int unsigned shape;
    int unsigned dir_mode;
    int unsigned base_h;
    int unsigned base_p;
    pdsc_in_t    req;
    shape = $urandom_range(0, 9);
    dir_mode = $urandom_range(0, 3);
    base_p = $urandom_range(1, 65535);
    base_h = (base_p * $urandom_range(0, 32768)) >> 15;
    case (shape)
      0: begin
        base_p = 0;
        base_h = $urandom_range(0, 65535);
      end
      1: base_h = base_p + $urandom_range(0, 65535 - base_p);
      default: ;
    endcase
    for (int i = 0; i <= AVG_SAMPLES; i++) begin
      if (shape == 2) begin
        req.high_count = 16'($urandom);
        req.period_count = 16'($urandom);
      end else begin
        req.high_count = 16'(base_h ^ $urandom_range(0, 3));
        req.period_count = (base_p == 0) ? 16'd0 : 16'(base_p ^ $urandom_range(0, 3));
      end
      case (dir_mode)
        0, 1: begin
          req.dir_check_enable = 1'b1;
          req.dir_pin = dir_mode[0];
        end
        2: begin
          req.dir_check_enable = 1'($urandom_range(0, 1));
          req.dir_pin = 1'($urandom_range(0, 1));
        end
        default: begin
          req.dir_check_enable = 1'b1;
          req.dir_pin = ($urandom_range(0, 4) == 0);
        end
      endcase
      req.pwm_pin_level = 1'($urandom_range(0, 1));
      send_request(req);
    end
  endtask

  // hold off until every result is out and the front end has settled
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_speeds != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int sent;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_settings(settings_for(SET_TYPICAL));

    // zero period with pin high, zero period with pin low, then full complement
    // duty after the backward vote has settled
    send_set(16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b1);
    send_set(16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1);
    send_set(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      write_settings(settings_for((seg == 0) ? SET_HIGH : (seg == 3) ? SET_LOW : SET_RANDOM));
      if (seg < 2) begin
        tx_idle_pct = 13;
        rx_idle_pct = 50;
      end else if (seg < 4) begin
        tx_idle_pct = 50;
        rx_idle_pct = 13;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      sent = 0;
      while (sent < RANDOM_ITEMS / SEGMENTS) begin
        send_random_set();
        sent += AVG_SAMPLES + 1;
      end
    end
    drain();

    if (mismatch_count == 0 && pending_speeds == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
